/* rtl/noise_floor_scan_rejector_core_assert.svh */
// Assertion macros used by the noise floor scan rejector RTL.
// Each macro expects clk and rst_n in scope.
`ifndef NOISE_FLOOR_SCAN_REJECTOR_CORE_ASSERT_SVH
`define NOISE_FLOOR_SCAN_REJECTOR_CORE_ASSERT_SVH

// same-cycle implication
`define NFSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NFSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nfsr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nfsr_pkg;

    localparam logic [15:0] RUN_LIMIT = 16'd64;
    localparam int          IIR_SHIFT = 3;

    localparam logic        REJECT_ENABLE_RST    = 1'b1;
    localparam logic [7:0]  DETECTION_MARGIN_RST = 8'd6;
    localparam logic [15:0] RUN_MAX              = 16'hFFFF;

    typedef enum logic [1:0] {
        REQ_TEST  = 2'd0,
        REQ_COUNT = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    typedef enum logic {
        CFG_REJECT_ENABLE    = 1'b0,
        CFG_DETECTION_MARGIN = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] floor_q8;
        logic        floor_seeded;
        logic [15:0] detect_run;
        logic [31:0] total_count;
        logic [31:0] rejected_count;
    } state_t;

    typedef struct packed {
        logic        reject;
        logic        lifted;
        logic [7:0]  floor_level;
        logic [31:0] steps_total;
        logic [31:0] steps_rejected;
    } result_t;

endpackage

`default_nettype wire

/* rtl/nfsr_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface nfsr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rssi_level;

    modport source (output valid, output req_type, output rssi_level, input ready);
    modport sink   (input valid, input req_type, input rssi_level, output ready);
endinterface

`default_nettype wire

/* rtl/nfsr_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface nfsr_res_if;
    logic        valid;
    logic        ready;
    logic        reject;
    logic        lifted;
    logic [7:0]  floor_level;
    logic [31:0] steps_total;
    logic [31:0] steps_rejected;

    modport source (output valid, output reject, output lifted, output floor_level,
                    output steps_total, output steps_rejected, input ready);
    modport sink   (input valid, input reject, input lifted, input floor_level,
                    input steps_total, input steps_rejected, output ready);
endinterface

`default_nettype wire

/* rtl/nfsr_update.sv */
`timescale 1ns / 1ps
`default_nettype none

module nfsr_update (
    input  wire logic             reject_enable,
    input  wire logic [7:0]       detection_margin,
    input  wire logic [1:0]       req_type,
    input  wire logic [7:0]       rssi_level,
    input  wire nfsr_pkg::state_t state_cur,
    output nfsr_pkg::state_t      state_next,
    output nfsr_pkg::result_t     result
);

    logic [15:0]        sample_q8;
    logic [15:0]        seed_q8;
    logic [8:0]         thresh;
    logic               is_lifted;
    logic               move;
    logic signed [16:0] diff;
    logic signed [16:0] step;
    logic signed [16:0] moved;

    always_comb
    begin
        sample_q8 = {rssi_level, 8'h00};
        // seed from the sample when the floor is not yet learned
        seed_q8   = state_cur.floor_seeded ? state_cur.floor_q8 : sample_q8;
        thresh    = {1'b0, seed_q8[15:8]} + {1'b0, detection_margin};
        is_lifted = {1'b0, rssi_level} >= thresh;
        move      = !is_lifted || (state_cur.detect_run >= nfsr_pkg::RUN_LIMIT);
        diff      = $signed({1'b0, sample_q8}) - $signed({1'b0, seed_q8});
        step      = diff >>> nfsr_pkg::IIR_SHIFT;
        moved     = $signed({1'b0, seed_q8}) + step;
    end

    always_comb
    begin
        state_next    = state_cur;
        result.reject = 1'b0;
        result.lifted = 1'b0;
        case (nfsr_pkg::req_t'(req_type))
            nfsr_pkg::REQ_TEST:
            begin
                if (reject_enable)
                begin
                    state_next.floor_seeded = 1'b1;
                    state_next.floor_q8     = move ? moved[15:0] : seed_q8;
                    if (is_lifted)
                    begin
                        result.lifted = 1'b1;
                        if (state_cur.detect_run != nfsr_pkg::RUN_MAX)
                        begin
                            state_next.detect_run = state_cur.detect_run + 16'd1;
                        end
                    end
                    else
                    begin
                        result.reject            = 1'b1;
                        state_next.detect_run     = '0;
                        state_next.rejected_count = state_cur.rejected_count + 32'd1;
                    end
                end
            end
            nfsr_pkg::REQ_COUNT:
            begin
                state_next.total_count = state_cur.total_count + 32'd1;
            end
            nfsr_pkg::REQ_CLEAR:
            begin
                state_next = '0;
            end
            default:
            begin
                state_next = state_cur;
            end
        endcase
        result.floor_level    = state_next.floor_seeded ? state_next.floor_q8[15:8] : 8'd0;
        result.steps_total    = state_next.total_count;
        result.steps_rejected = state_next.rejected_count;
    end

endmodule

`default_nettype wire

/* rtl/noise_floor_scan_rejector_core.sv */
// Path: an accepted request word is held in the input register, its result word in the output register on res.
// Throughput: one word per cycle while res accepts; the floor update loops
// through the state registers with no extra stage, so words stream back to back.
// A stalled res side backs up into the input register, then drops req.ready.
// Reset (rst_n, async, active low) clears floor, run and counters, empties
// both stages and loads reject_enable = 1, detection_margin = 6.
`timescale 1ns / 1ps
`default_nettype none

`include "noise_floor_scan_rejector_core_assert.svh"

module noise_floor_scan_rejector_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    nfsr_req_if.sink        req,
    nfsr_res_if.source      res,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_wdata
);

    logic              reject_enable_reg;
    logic [7:0]        detection_margin_reg;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [1:0]        in_type_reg;
    logic [7:0]        in_rssi_reg;

    nfsr_pkg::state_t  state_reg;
    nfsr_pkg::state_t  state_next;
    nfsr_pkg::result_t res_reg;
    nfsr_pkg::result_t res_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic              req_take;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_take = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reject_enable_reg    <= nfsr_pkg::REJECT_ENABLE_RST;
            detection_margin_reg <= nfsr_pkg::DETECTION_MARGIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (nfsr_pkg::cfg_idx_t'(cfg_index))
                nfsr_pkg::CFG_REJECT_ENABLE:    reject_enable_reg    <= cfg_wdata[0];
                nfsr_pkg::CFG_DETECTION_MARGIN: detection_margin_reg <= cfg_wdata;
                default:                        reject_enable_reg    <= reject_enable_reg;
            endcase
        end
    end

    nfsr_update u_update (
        .reject_enable    (reject_enable_reg),
        .detection_margin (detection_margin_reg),
        .req_type         (in_type_reg),
        .rssi_level       (in_rssi_reg),
        .state_cur        (state_reg),
        .state_next       (state_next),
        .result           (res_next)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (req_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload holds; no reset needed
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_type_reg <= req.req_type;
            in_rssi_reg <= req.rssi_level;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.reject         = res_reg.reject;
    assign res.lifted         = res_reg.lifted;
    assign res.floor_level    = res_reg.floor_level;
    assign res.steps_total    = res_reg.steps_total;
    assign res.steps_rejected = res_reg.steps_rejected;

    `NFSR_ASSERT_NOW(a_floor_bound, 1'b1, state_reg.floor_q8 <= 16'hFF00, "floor above 0xFF00")
    `NFSR_ASSERT_NOW(a_unseeded_clean, !state_reg.floor_seeded,
        (state_reg.floor_q8 == 16'd0) && (state_reg.detect_run == 16'd0),
        "unseeded floor carries state")
    `NFSR_ASSERT_NOW(a_flags_exclusive, out_valid_reg, !(res_reg.reject && res_reg.lifted),
        "reject and lifted both set")
    `NFSR_ASSERT_NEXT(a_count_hold, !advance, $stable(state_reg.total_count),
        "step count moved without a word")

endmodule

`default_nettype wire
